// ----- rtl/mvwo_pkg.sv -----
// ----------------------------------------------------------------------------
// Oscillator bank package
// Shared widths, input codes, the request type passed from the front end to
// the back end, and the pitch-to-period table.
// ----------------------------------------------------------------------------
`default_nettype none

package mvwo_pkg;

  localparam int NUM_VOICES = 8;
  localparam int VIDX_W     = (NUM_VOICES > 1) ? $clog2(NUM_VOICES) : 1;

  localparam int FUNC_W   = 3;
  localparam int VOICE_W  = 3;
  localparam int VALUE_W  = 8;
  localparam int SAMPLE_W = 8;
  localparam int PITCH_W  = 7;
  localparam int VEL_W    = 8;
  localparam int COUNT_W  = 14;

  localparam logic [PITCH_W-1:0] PITCH_MAX = 7'd126;

  // Input function codes.
  localparam logic [FUNC_W-1:0] FUNC_SET_PITCH = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SET_VEL   = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_SAW       = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_TRIANGLE  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_SQUARE    = 3'd4;

  // Request classes decided by the front end.
  typedef enum logic [2:0] {
    OP_SET_PITCH,
    OP_SET_VEL,
    OP_SAW,
    OP_TRIANGLE,
    OP_SQUARE,
    OP_ECHO,
    OP_NULL
  } op_kind_e;

  typedef struct packed {
    op_kind_e            kind;
    logic [VIDX_W-1:0]   voice;
    logic [VALUE_W-1:0]  value;
  } op_t;

  // Period length in samples for each pitch.
  localparam logic [COUNT_W-1:0] PERIOD_TABLE [127] = '{
    14'd9785, 14'd9236, 14'd8717, 14'd8228, 14'd7766, 14'd7330, 14'd6919, 14'd6531,
    14'd6164, 14'd5818, 14'd5492, 14'd5183, 14'd4892, 14'd4618, 14'd4359, 14'd4114,
    14'd3883, 14'd3665, 14'd3460, 14'd3265, 14'd3082, 14'd2909, 14'd2746, 14'd2592,
    14'd2446, 14'd2309, 14'd2179, 14'd2057, 14'd1942, 14'd1833, 14'd1730, 14'd1633,
    14'd1541, 14'd1455, 14'd1373, 14'd1296, 14'd1223, 14'd1154, 14'd1090, 14'd1029,
    14'd971,  14'd916,  14'd865,  14'd816,  14'd771,  14'd727,  14'd686,  14'd648,
    14'd612,  14'd577,  14'd545,  14'd514,  14'd485,  14'd458,  14'd432,  14'd408,
    14'd385,  14'd364,  14'd343,  14'd324,  14'd306,  14'd289,  14'd272,  14'd257,
    14'd243,  14'd229,  14'd216,  14'd204,  14'd193,  14'd182,  14'd172,  14'd162,
    14'd153,  14'd144,  14'd136,  14'd129,  14'd121,  14'd115,  14'd108,  14'd102,
    14'd96,   14'd91,   14'd86,   14'd81,   14'd76,   14'd72,   14'd68,   14'd64,
    14'd61,   14'd57,   14'd54,   14'd51,   14'd48,   14'd45,   14'd43,   14'd40,
    14'd38,   14'd36,   14'd34,   14'd32,   14'd30,   14'd29,   14'd27,   14'd26,
    14'd24,   14'd23,   14'd21,   14'd20,   14'd19,   14'd18,   14'd17,   14'd16,
    14'd15,   14'd14,   14'd14,   14'd13,   14'd12,   14'd11,   14'd11,   14'd10,
    14'd10,   14'd9,    14'd9,    14'd8,    14'd8,    14'd7,    14'd7
  };

  // Pitches above the top of the table use the top entry.
  function automatic logic [COUNT_W-1:0] period_of(input logic [PITCH_W-1:0] pitch);
    logic [PITCH_W-1:0] idx;
    idx = (pitch > PITCH_MAX) ? PITCH_MAX : pitch;
    return PERIOD_TABLE[idx];
  endfunction

endpackage

`default_nettype wire

// ----- rtl/mvwo_front.sv -----
// ----------------------------------------------------------------------------
// Oscillator bank front end
// Takes incoming requests, decodes and clamps them, and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none

module mvwo_front
  import mvwo_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [FUNC_W-1:0]  func_i,
  input  wire logic [VOICE_W-1:0] voice_i,
  input  wire logic [VALUE_W-1:0] value_i,
  output logic                    op_valid_o,
  output op_t                     op_o,
  input  wire logic               op_pop_i
);

  localparam int QDEPTH = 2;

  op_t        queue_q [QDEPTH];
  logic       wr_ptr_q, wr_ptr_d;
  logic       rd_ptr_q, rd_ptr_d;
  logic [1:0] fill_q, fill_d;
  op_t        op_new;
  logic       push, pop;

  // Decode the incoming request.
  always_comb begin
    op_new.voice = VIDX_W'(voice_i);
    op_new.value = value_i;
    if (int'(voice_i) >= NUM_VOICES) begin
      op_new.kind = OP_NULL;
    end else begin
      case (func_i)
        FUNC_SET_PITCH: begin
          op_new.kind  = OP_SET_PITCH;
          op_new.value = (value_i > {1'b0, PITCH_MAX}) ? {1'b0, PITCH_MAX} : value_i;
        end
        FUNC_SET_VEL:  op_new.kind = OP_SET_VEL;
        FUNC_SAW:      op_new.kind = OP_SAW;
        FUNC_TRIANGLE: op_new.kind = OP_TRIANGLE;
        FUNC_SQUARE:   op_new.kind = OP_SQUARE;
        default:       op_new.kind = OP_ECHO;
      endcase
    end
  end

  assign in_stall_o = (fill_q == 2'(QDEPTH));
  assign push       = in_valid_i && !in_stall_o;
  assign op_valid_o = (fill_q != 2'd0);
  assign pop        = op_pop_i && op_valid_o;
  assign op_o       = queue_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      queue_q[wr_ptr_q] <= op_new;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/mvwo_back.sv -----
// ----------------------------------------------------------------------------
// Oscillator bank back end
// Holds the voice state, executes one queued request at a time with an
// eight-step restoring divider, and drives the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module mvwo_back
  import mvwo_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                op_valid_i,
  input  wire op_t                 op_i,
  output logic                     op_pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SAMPLE_W-1:0]      sample_o,
  output logic [PITCH_W-1:0]       pitch_now_o,
  output logic [VEL_W-1:0]         velocity_now_o
);

  localparam int NUM_W = 24;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHAPE,
    ST_MUL,
    ST_ADD,
    ST_CHECK,
    ST_DIV,
    ST_DONE
  } state_e;

  state_e              state_q;
  logic [COUNT_W-1:0]  count_q [NUM_VOICES];
  logic [PITCH_W-1:0]  pitch_q [NUM_VOICES];
  logic [VEL_W-1:0]    vel_q   [NUM_VOICES];

  op_kind_e            kind_q;
  logic [VIDX_W-1:0]   idx_q;
  logic [COUNT_W-1:0]  c_q, p_q, x_q, d_q;
  logic [VEL_W-1:0]    v_q;
  logic [21:0]         prod_q;
  logic [NUM_W-1:0]    lim_q, num_q, rem_q;
  logic [SAMPLE_W-1:0] quo_q;
  logic [2:0]          bit_q;

  logic [SAMPLE_W-1:0] res_sample_q;
  logic [PITCH_W-1:0]  res_pitch_q;
  logic [VEL_W-1:0]    res_vel_q;

  logic                out_valid_q;
  logic [SAMPLE_W-1:0] out_sample_q;
  logic [PITCH_W-1:0]  out_pitch_q;
  logic [VEL_W-1:0]    out_vel_q;

  logic [COUNT_W-1:0]  half, two_half, c_next;
  logic [21:0]         prod;
  logic [NUM_W-1:0]    lim, den, den_sh, rem_next;
  logic                ge;
  logic [SAMPLE_W-1:0] quo_next;
  logic                slot_free;
  logic                load_out;

  assign op_pop_o  = (state_q == ST_IDLE) && op_valid_i;
  assign slot_free = !out_valid_q || !out_stall_i;
  assign load_out  = (state_q == ST_DONE) && slot_free;

  always_comb begin
    half     = p_q >> 1;
    two_half = {half[COUNT_W-2:0], 1'b0};
    c_next   = (c_q >= p_q) ? '0 : c_q + 14'd1;
    prod     = 22'(v_q) * 22'(x_q);
    den      = NUM_W'({d_q, 1'b0});
    lim      = NUM_W'({1'b0, v_q} + 9'd1) * den;
    den_sh   = den << bit_q;
    ge       = (rem_q >= den_sh);
    rem_next = ge ? rem_q - den_sh : rem_q;
    quo_next = quo_q | (ge ? (8'd1 << bit_q) : 8'd0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      for (int i = 0; i < NUM_VOICES; i++) begin
        count_q[i] <= '0;
        pitch_q[i] <= '0;
        vel_q[i]   <= '0;
      end
      kind_q       <= OP_NULL;
      idx_q        <= '0;
      c_q          <= '0;
      p_q          <= '0;
      x_q          <= '0;
      d_q          <= '0;
      v_q          <= '0;
      prod_q       <= '0;
      lim_q        <= '0;
      num_q        <= '0;
      rem_q        <= '0;
      quo_q        <= '0;
      bit_q        <= '0;
      res_sample_q <= '0;
      res_pitch_q  <= '0;
      res_vel_q    <= '0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_pitch_q  <= '0;
      out_vel_q    <= '0;
    end else begin
      if (load_out) begin
        out_valid_q  <= 1'b1;
        out_sample_q <= res_sample_q;
        out_pitch_q  <= res_pitch_q;
        out_vel_q    <= res_vel_q;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        ST_IDLE: begin
          if (op_valid_i) begin
            idx_q        <= op_i.voice;
            kind_q       <= op_i.kind;
            res_sample_q <= '0;
            c_q          <= count_q[op_i.voice];
            p_q          <= period_of(pitch_q[op_i.voice]);
            v_q          <= vel_q[op_i.voice];
            case (op_i.kind)
              OP_SET_PITCH: begin
                pitch_q[op_i.voice] <= op_i.value[PITCH_W-1:0];
                res_pitch_q         <= op_i.value[PITCH_W-1:0];
                res_vel_q           <= vel_q[op_i.voice];
                state_q             <= ST_DONE;
              end
              OP_SET_VEL: begin
                vel_q[op_i.voice] <= op_i.value;
                res_pitch_q       <= pitch_q[op_i.voice];
                res_vel_q         <= op_i.value;
                state_q           <= ST_DONE;
              end
              OP_SAW, OP_TRIANGLE, OP_SQUARE: begin
                res_pitch_q <= pitch_q[op_i.voice];
                res_vel_q   <= vel_q[op_i.voice];
                state_q     <= ST_SHAPE;
              end
              OP_ECHO: begin
                res_pitch_q <= pitch_q[op_i.voice];
                res_vel_q   <= vel_q[op_i.voice];
                state_q     <= ST_DONE;
              end
              default: begin
                res_pitch_q <= '0;
                res_vel_q   <= '0;
                state_q     <= ST_DONE;
              end
            endcase
          end
        end
        ST_SHAPE: begin
          count_q[idx_q] <= c_next;
          case (kind_q)
            OP_SQUARE: begin
              res_sample_q <= (c_q <= (p_q >> 4)) ? v_q : '0;
              state_q      <= ST_DONE;
            end
            OP_TRIANGLE: begin
              d_q <= half;
              if (c_q <= half) begin
                x_q     <= c_q;
                state_q <= ST_MUL;
              end else if (c_q >= two_half) begin
                res_sample_q <= '0;
                state_q      <= ST_DONE;
              end else begin
                x_q     <= two_half - c_q;
                state_q <= ST_MUL;
              end
            end
            default: begin
              x_q     <= c_q;
              d_q     <= p_q;
              state_q <= ST_MUL;
            end
          endcase
        end
        ST_MUL: begin
          prod_q  <= prod;
          lim_q   <= lim;
          state_q <= ST_ADD;
        end
        ST_ADD: begin
          num_q   <= NUM_W'({prod_q, 1'b0}) + NUM_W'(d_q);
          state_q <= ST_CHECK;
        end
        ST_CHECK: begin
          if (num_q >= lim_q) begin
            res_sample_q <= v_q;
            state_q      <= ST_DONE;
          end else begin
            rem_q   <= num_q;
            quo_q   <= '0;
            bit_q   <= 3'd7;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q <= rem_next;
          quo_q <= quo_next;
          bit_q <= bit_q - 3'd1;
          if (bit_q == 3'd0) begin
            res_sample_q <= quo_next;
            state_q      <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state_q <= ST_IDLE;
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o    = out_valid_q;
  assign sample_o       = out_sample_q;
  assign pitch_now_o    = out_pitch_q;
  assign velocity_now_o = out_vel_q;

  // A sample is always saturated to the voice velocity.
  a_sample_le_vel: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (sample_o <= velocity_now_o))
    else $error("sample above velocity");

  // Stored pitch is always clamped.
  a_pitch_clamped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (pitch_now_o <= PITCH_MAX))
    else $error("pitch above clamp");

  // The divider remainder stays below twice the current trial divisor, so
  // the quotient fits in eight bits.
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < (den << (4'(bit_q) + 4'd1))))
    else $error("divider remainder out of range");

  // A new result is only loaded when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && out_stall_i) |=> (out_valid_q && $stable(out_sample_q)))
    else $error("stalled result overwritten");

endmodule

`default_nettype wire

// ----- rtl/multi_voice_wave_oscillator.sv -----
// ----------------------------------------------------------------------------
// Multi-voice wave oscillator
// Eight-voice table-driven oscillator bank producing saw, triangle and
// square samples scaled by each voice's velocity.
// ----------------------------------------------------------------------------
// Each request either sets a voice's pitch (clamped to 126) or velocity, or
// asks for the next saw, triangle or square sample of that voice, which also
// advances the voice's phase counter. Every request returns exactly one
// result carrying the sample (zero for set requests) and the voice's pitch
// and velocity after the request; a request for a voice outside the bank
// returns all zeros. Requests pass through a two-entry queue, so up to two
// can be taken while the back end is busy, and a finished result waits in an
// output register while the next request is already being worked on. The
// back end handles one request at a time: a set request or an unused function
// code goes from idle straight to done, a square sample or a triangle sample
// whose counter is at or past twice the half period passes through the shape
// step, a saturated saw or triangle sample through the shape, multiply, add
// and check steps, and any other saw or triangle sample then also through the
// eight-step restoring divider that forms the rounded quotient. A finished
// result that finds the output register still stalled holds the back end for
// as long as that stall lasts.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_voice_wave_oscillator
  import mvwo_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                in_valid_i,
  output logic                     in_stall_o,
  input  wire logic [FUNC_W-1:0]   func_i,
  input  wire logic [VOICE_W-1:0]  voice_i,
  input  wire logic [VALUE_W-1:0]  value_i,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [SAMPLE_W-1:0]      sample_o,
  output logic [PITCH_W-1:0]       pitch_now_o,
  output logic [VEL_W-1:0]         velocity_now_o
);

  // Decoded requests queued between the front and back ends.
  logic op_valid;
  logic op_pop;
  op_t  op;

  // The front end decodes each request and buffers it.
  mvwo_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .func_i     (func_i),
    .voice_i    (voice_i),
    .value_i    (value_i),
    .op_valid_o (op_valid),
    .op_o       (op),
    .op_pop_i   (op_pop)
  );

  // The back end owns the voice state and produces the results.
  mvwo_back u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .op_valid_i     (op_valid),
    .op_i           (op),
    .op_pop_o       (op_pop),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .sample_o       (sample_o),
    .pitch_now_o    (pitch_now_o),
    .velocity_now_o (velocity_now_o)
  );

endmodule

`default_nettype wire
